/* rtl/tstm_pkg.sv */
// shared types and codes for the two-stream timestamp merger
`default_nettype none

package tstm_pkg;

  localparam int unsigned DEF_QUEUE_DEPTH = 16;

  localparam logic [1:0] CMD_PUSH_A = 2'd0;
  localparam logic [1:0] CMD_PUSH_B = 2'd1;
  localparam logic [1:0] CMD_POP    = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_ORDER = 2'd2;
  localparam logic [1:0] STAT_FULL  = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] stamp;
  } in_t;

  typedef struct packed {
    logic               has_item;
    logic signed [31:0] item;
    logic               from_b;
    logic [1:0]         status;
    logic [4:0]         count_a;
    logic [4:0]         count_b;
  } out_t;

endpackage

`default_nettype wire

/* rtl/two_stream_timestamp_merger.sv */
// two-stream timestamp merger: ordered push fifos per source and a stable merged pop
// timing: the accepting edge registers the command, the exec state then registers the result,
// and the result strobe is registered alongside it
// commands: none is taken while busy; busy is high for the cycle after an accept,
// while the registered command and the queue heads read at the accepting edge execute
// the strobe cycle overlaps the next accept; results cannot be stalled
// reset: synchronous, both queues empty and newest stamps zero, no clearing pass
`default_nettype none

module two_stream_timestamp_merger
  import tstm_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W = CNT_W + 1;

  logic [31:0] mem_a [QUEUE_DEPTH];
  logic [31:0] mem_b [QUEUE_DEPTH];

  state_t state_r, state_nxt;

  logic [1:0]         cmd_r;
  logic signed [31:0] stamp_r;
  logic signed [31:0] rd_a_r, rd_b_r;

  logic [IDX_W-1:0]   head_a_r, head_a_nxt, head_b_r, head_b_nxt;
  logic [CNT_W-1:0]   fill_a_r, fill_a_nxt, fill_b_r, fill_b_nxt;
  logic signed [31:0] newest_a_r, newest_a_nxt, newest_b_r, newest_b_nxt;

  logic out_valid_r, out_valid_nxt;
  out_t out_r, out_nxt;

  logic             accept, exec;
  logic             wr_a, wr_b;
  logic [IDX_W-1:0] tail_a, tail_b;
  logic [SUM_W-1:0] sum_a, sum_b;

  // tail = (head + fill) mod depth, sum stays below twice the depth
  always_comb begin
    sum_a = SUM_W'(head_a_r) + SUM_W'(fill_a_r);
    sum_b = SUM_W'(head_b_r) + SUM_W'(fill_b_r);
    if (sum_a >= SUM_W'(QUEUE_DEPTH)) begin
      sum_a = sum_a - SUM_W'(QUEUE_DEPTH);
    end
    if (sum_b >= SUM_W'(QUEUE_DEPTH)) begin
      sum_b = sum_b - SUM_W'(QUEUE_DEPTH);
    end
    tail_a = IDX_W'(sum_a);
    tail_b = IDX_W'(sum_b);
  end

  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[tail_a] <= stamp_r;
    end
    if (wr_b) begin
      mem_b[tail_b] <= stamp_r;
    end
    rd_a_r <= mem_a[head_a_r];
    rd_b_r <= mem_b[head_b_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_a_r    <= '0;
      head_b_r    <= '0;
      fill_a_r    <= '0;
      fill_b_r    <= '0;
      newest_a_r  <= '0;
      newest_b_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_a_r    <= head_a_nxt;
      head_b_r    <= head_b_nxt;
      fill_a_r    <= fill_a_nxt;
      fill_b_r    <= fill_b_nxt;
      newest_a_r  <= newest_a_nxt;
      newest_b_r  <= newest_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r   <= in_data.cmd;
      stamp_r <= in_data.stamp;
    end
    if (exec) begin
      out_r <= out_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy      = 1'b0;
    accept    = 1'b0;
    exec      = 1'b0;
    case (state_r)
      S_IDLE: begin
        accept = start;
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        busy      = 1'b1;
        exec      = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    logic take_b;
    take_b        = 1'b0;
    head_a_nxt    = head_a_r;
    head_b_nxt    = head_b_r;
    fill_a_nxt    = fill_a_r;
    fill_b_nxt    = fill_b_r;
    newest_a_nxt  = newest_a_r;
    newest_b_nxt  = newest_b_r;
    wr_a          = 1'b0;
    wr_b          = 1'b0;
    out_valid_nxt = exec;
    out_nxt       = '0;
    if (exec) begin
      case (cmd_r)
        CMD_PUSH_A: begin
          if (fill_a_r != '0 && stamp_r < newest_a_r) begin
            out_nxt.status = STAT_ORDER;
          end else if (fill_a_r == CNT_W'(QUEUE_DEPTH)) begin
            out_nxt.status = STAT_FULL;
          end else begin
            wr_a         = 1'b1;
            fill_a_nxt   = fill_a_r + CNT_W'(1);
            newest_a_nxt = stamp_r;
          end
        end
        CMD_PUSH_B: begin
          if (fill_b_r != '0 && stamp_r < newest_b_r) begin
            out_nxt.status = STAT_ORDER;
          end else if (fill_b_r == CNT_W'(QUEUE_DEPTH)) begin
            out_nxt.status = STAT_FULL;
          end else begin
            wr_b         = 1'b1;
            fill_b_nxt   = fill_b_r + CNT_W'(1);
            newest_b_nxt = stamp_r;
          end
        end
        CMD_POP: begin
          if (fill_a_r == '0 && fill_b_r == '0) begin
            out_nxt.status = STAT_EMPTY;
          end else begin
            // equal heads go to stream a
            if (fill_a_r == '0) begin
              take_b = 1'b1;
            end else if (fill_b_r == '0) begin
              take_b = 1'b0;
            end else begin
              take_b = rd_b_r < rd_a_r;
            end
            out_nxt.has_item = 1'b1;
            out_nxt.from_b   = take_b;
            if (take_b) begin
              out_nxt.item = rd_b_r;
              fill_b_nxt   = fill_b_r - CNT_W'(1);
              head_b_nxt   = (head_b_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : head_b_r + IDX_W'(1);
            end else begin
              out_nxt.item = rd_a_r;
              fill_a_nxt   = fill_a_r - CNT_W'(1);
              head_a_nxt   = (head_a_r == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : head_a_r + IDX_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
      out_nxt.count_a = 5'(fill_a_nxt);
      out_nxt.count_b = 5'(fill_b_nxt);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
